### hdl/bts_pkg.sv
// bts_pkg: shared constants, types and helpers for the bilinear texture sampler
// no dependencies

package bts_pkg;

    localparam int MAX_TEXELS  = 65536;
    localparam int TEX_ADDR_W  = $clog2(MAX_TEXELS);
    localparam int WEIGHT_BITS = 8;
    localparam int FRAC_BITS   = 16;

    localparam int COORD_W     = 18;
    localparam int SIZE_W      = 9;
    localparam int IDX_W       = 8;
    localparam int POS_W       = COORD_W + SIZE_W;
    localparam int ROW_W       = IDX_W + SIZE_W;
    localparam int IN_ADDR_W   = 16;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int TEXEL_W     = CH_W * NUM_CH;
    localparam int HSUM_W      = CH_W + WEIGHT_BITS;
    localparam int VSUM_W      = CH_W + 2 * WEIGHT_BITS;

    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = TEXEL_W;
    localparam int TD_ADDR_LSB = 0;
    localparam int TD_TEX_LSB  = TD_ADDR_LSB + IN_ADDR_W;
    localparam int TD_U_LSB    = TD_TEX_LSB + TEXEL_W;
    localparam int TD_V_LSB    = TD_U_LSB + COORD_W;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_TEX_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TEX_HEIGHT = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } texel_t;

    typedef struct packed {
        logic [IDX_W-1:0]       near_idx;
        logic [IDX_W-1:0]       far_idx;
        logic [WEIGHT_BITS-1:0] weight;
    } loc_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] r;
        r = raw;
        if (raw < SIZE_MIN)
        begin
            r = SIZE_MIN;
        end
        else if (raw > SIZE_MAX)
        begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

### hdl/bts_ram.sv
// bts_ram: generic single-write, dual-read synchronous ram with registered reads
// no dependencies

module bts_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hdl/bts_locate.sv
// bts_locate: scales one q2.16 coordinate by the texture size, clamps it and
// splits it into near index, far index and weight; depends on bts_pkg

module bts_locate (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [bts_pkg::COORD_W-1:0] coord,
    input  logic        [bts_pkg::SIZE_W-1:0]  size,
    output bts_pkg::loc_t                      loc
);

    logic signed [bts_pkg::POS_W-1:0] pos_reg;
    logic signed [bts_pkg::POS_W-1:0] pos_next;
    logic signed [bts_pkg::POS_W-1:0] coord_ext;
    logic signed [bts_pkg::POS_W-1:0] size_ext;
    logic signed [bts_pkg::POS_W-1:0] pos_hi;
    logic signed [bts_pkg::POS_W-1:0] pos_clamped;
    logic [bts_pkg::SIZE_W-1:0]       size_m1;
    logic [bts_pkg::SIZE_W-1:0]       far_wide;
    logic [bts_pkg::FRAC_BITS-1:0]    frac;
    bts_pkg::loc_t                    loc_reg;
    bts_pkg::loc_t                    loc_next;

    // scale
    always_comb
    begin
        coord_ext = bts_pkg::POS_W'(coord);
        size_ext  = $signed({{(bts_pkg::POS_W - bts_pkg::SIZE_W){1'b0}}, size});
        pos_next  = coord_ext * size_ext;
    end

    // clamp and split
    always_comb
    begin
        size_m1     = size - bts_pkg::SIZE_W'(1);
        pos_hi      = $signed({{(bts_pkg::POS_W - bts_pkg::SIZE_W - bts_pkg::FRAC_BITS){1'b0}},
                               size_m1, {bts_pkg::FRAC_BITS{1'b0}}});
        pos_clamped = pos_reg;
        if (pos_reg < 0)
        begin
            pos_clamped = '0;
        end
        else if (pos_reg > pos_hi)
        begin
            pos_clamped = pos_hi;
        end
        frac              = pos_clamped[bts_pkg::FRAC_BITS-1:0];
        loc_next.near_idx = pos_clamped[bts_pkg::FRAC_BITS +: bts_pkg::IDX_W];
        far_wide          = bts_pkg::SIZE_W'(loc_next.near_idx)
                          + bts_pkg::SIZE_W'(frac != '0);
        if (far_wide > size_m1)
        begin
            far_wide = size_m1;
        end
        loc_next.far_idx  = far_wide[bts_pkg::IDX_W-1:0];
        loc_next.weight   = frac[bts_pkg::FRAC_BITS-1 -: bts_pkg::WEIGHT_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
            loc_reg <= loc_next;
        end
    end

    assign loc = loc_reg;

endmodule

### hdl/bts_blend.sv
// bts_blend: two-stage per-channel bilinear blend with round half up
// depends on bts_pkg

module bts_blend (
    input  logic                            clk,
    input  logic                            en,
    input  bts_pkg::texel_t                 t00,
    input  bts_pkg::texel_t                 t10,
    input  bts_pkg::texel_t                 t01,
    input  bts_pkg::texel_t                 t11,
    input  logic [bts_pkg::WEIGHT_BITS-1:0] wx,
    input  logic [bts_pkg::WEIGHT_BITS-1:0] wy,
    output bts_pkg::texel_t                 result
);

    localparam int WC_W = bts_pkg::WEIGHT_BITS + 1;
    localparam logic [WC_W-1:0] WEIGHT_ONE = WC_W'(1) << bts_pkg::WEIGHT_BITS;
    localparam logic [bts_pkg::VSUM_W:0] ROUND_HALF =
        (bts_pkg::VSUM_W + 1)'(1) << (2 * bts_pkg::WEIGHT_BITS - 1);
    localparam logic [bts_pkg::VSUM_W:0] CH_MAX = (bts_pkg::VSUM_W + 1)'(255);

    logic [bts_pkg::HSUM_W-1:0]      top_reg  [bts_pkg::NUM_CH];
    logic [bts_pkg::HSUM_W-1:0]      bot_reg  [bts_pkg::NUM_CH];
    logic [bts_pkg::HSUM_W-1:0]      top_next [bts_pkg::NUM_CH];
    logic [bts_pkg::HSUM_W-1:0]      bot_next [bts_pkg::NUM_CH];
    logic [bts_pkg::VSUM_W:0]        rnd      [bts_pkg::NUM_CH];
    logic [bts_pkg::WEIGHT_BITS-1:0] wy_reg;
    logic [WC_W-1:0]                 wxc;
    logic [WC_W-1:0]                 wyc;
    logic [bts_pkg::TEXEL_W-1:0]     res_next;
    logic [bts_pkg::TEXEL_W-1:0]     res_reg;

    // horizontal
    always_comb
    begin
        wxc = WEIGHT_ONE - WC_W'(wx);
        for (int c = 0; c < bts_pkg::NUM_CH; c++)
        begin
            top_next[c] = bts_pkg::HSUM_W'(t00[c*bts_pkg::CH_W +: bts_pkg::CH_W])
                        * bts_pkg::HSUM_W'(wxc)
                        + bts_pkg::HSUM_W'(t10[c*bts_pkg::CH_W +: bts_pkg::CH_W])
                        * bts_pkg::HSUM_W'(wx);
            bot_next[c] = bts_pkg::HSUM_W'(t01[c*bts_pkg::CH_W +: bts_pkg::CH_W])
                        * bts_pkg::HSUM_W'(wxc)
                        + bts_pkg::HSUM_W'(t11[c*bts_pkg::CH_W +: bts_pkg::CH_W])
                        * bts_pkg::HSUM_W'(wx);
        end
    end

    // vertical and rounding
    always_comb
    begin
        wyc = WEIGHT_ONE - WC_W'(wy_reg);
        for (int c = 0; c < bts_pkg::NUM_CH; c++)
        begin
            rnd[c] = ((bts_pkg::VSUM_W + 1)'(top_reg[c]) * (bts_pkg::VSUM_W + 1)'(wyc)
                    + (bts_pkg::VSUM_W + 1)'(bot_reg[c]) * (bts_pkg::VSUM_W + 1)'(wy_reg)
                    + ROUND_HALF) >> (2 * bts_pkg::WEIGHT_BITS);
            if (rnd[c] > CH_MAX)
            begin
                rnd[c] = CH_MAX;
            end
            res_next[c*bts_pkg::CH_W +: bts_pkg::CH_W] = rnd[c][bts_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < bts_pkg::NUM_CH; c++)
            begin
                top_reg[c] <= top_next[c];
                bot_reg[c] <= bot_next[c];
            end
            wy_reg  <= wy;
            res_reg <= res_next;
        end
    end

    assign result = bts_pkg::texel_t'(res_reg);

endmodule

### hdl/bilinear_texture_sampler.sv
// bilinear_texture_sampler: top level, texel store, address generation and output skid
// depends on bts_pkg, bts_ram, bts_locate, bts_blend
//
// channel   dir  handshake          payload
// s_        in   tvalid/tready      tdata: address, texel, u, v; tuser: cmd
// m_        out  tvalid/tready      tdata: filtered rgba
// cfg_      in   we (no wait)       index, data
//
// one beat per cycle in, one sample result per cycle out, unless stalled
// a sample passes the input, locate, address, ram, blend and output registers to m_
// the store is two copies of a dual-read ram: four texel reads per unstalled cycle
// texel store has no clearing pass and holds nothing defined until written
// a full output skid register stalls the whole pipeline and drops s_tready

module bilinear_texture_sampler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] texel_address, [23:16] red, [31:24] green, [39:32] blue,
    // [47:40] alpha, [65:48] u_coord, [83:66] v_coord, [87:84] zero
    input  logic [bts_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] cmd
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    output logic [bts_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [bts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [bts_pkg::SIZE_W-1:0] tex_w_reg;
    logic [bts_pkg::SIZE_W-1:0] tex_h_reg;

    logic pipe_en;
    logic push;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic s1_cmd_reg, s2_cmd_reg, s3_cmd_reg, s4_cmd_reg;

    logic [bts_pkg::IN_ADDR_W-1:0] s1_addr_reg, s2_addr_reg, s3_addr_reg, s4_addr_reg;
    bts_pkg::texel_t               s1_texel_reg, s2_texel_reg, s3_texel_reg, s4_texel_reg;
    logic signed [bts_pkg::COORD_W-1:0] s1_u_reg;
    logic signed [bts_pkg::COORD_W-1:0] s1_v_reg;

    bts_pkg::loc_t loc_x;
    bts_pkg::loc_t loc_y;

    logic [bts_pkg::ROW_W-1:0]       row0_reg, row1_reg;
    logic [bts_pkg::IDX_W-1:0]       x0_reg, x1_reg;
    logic [bts_pkg::WEIGHT_BITS-1:0] wx4_reg, wy4_reg, wx5_reg, wy5_reg;

    logic [bts_pkg::TEX_ADDR_W-1:0] idx00, idx10, idx01, idx11, waddr;
    logic                           ram_we;
    logic [bts_pkg::TEXEL_W-1:0]    rd00, rd10, rd01, rd11;

    bts_pkg::texel_t result;
    bts_pkg::texel_t out_data_reg;
    bts_pkg::texel_t skid_data_reg;
    logic            out_valid_reg;
    logic            skid_valid_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;
    assign push     = pipe_en && s7_valid_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_w_reg <= bts_pkg::SIZE_MAX;
            tex_h_reg <= bts_pkg::SIZE_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bts_pkg::REG_TEX_WIDTH:  tex_w_reg <= bts_pkg::eff_size(cfg_data);
                bts_pkg::REG_TEX_HEIGHT: tex_h_reg <= bts_pkg::eff_size(cfg_data);
                default: ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg && (s4_cmd_reg == bts_pkg::CMD_SAMPLE);
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_cmd_reg   <= s_tuser;
            s1_addr_reg  <= s_tdata[bts_pkg::TD_ADDR_LSB +: bts_pkg::IN_ADDR_W];
            s1_texel_reg <= bts_pkg::texel_t'(s_tdata[bts_pkg::TD_TEX_LSB +: bts_pkg::TEXEL_W]);
            s1_u_reg     <= $signed(s_tdata[bts_pkg::TD_U_LSB +: bts_pkg::COORD_W]);
            s1_v_reg     <= $signed(s_tdata[bts_pkg::TD_V_LSB +: bts_pkg::COORD_W]);

            s2_cmd_reg   <= s1_cmd_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_texel_reg <= s1_texel_reg;
            s3_cmd_reg   <= s2_cmd_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_texel_reg <= s2_texel_reg;
            s4_cmd_reg   <= s3_cmd_reg;
            s4_addr_reg  <= s3_addr_reg;
            s4_texel_reg <= s3_texel_reg;

            row0_reg <= bts_pkg::ROW_W'(loc_y.near_idx) * bts_pkg::ROW_W'(tex_w_reg);
            row1_reg <= bts_pkg::ROW_W'(loc_y.far_idx) * bts_pkg::ROW_W'(tex_w_reg);
            x0_reg   <= loc_x.near_idx;
            x1_reg   <= loc_x.far_idx;
            wx4_reg  <= loc_x.weight;
            wy4_reg  <= loc_y.weight;
            wx5_reg  <= wx4_reg;
            wy5_reg  <= wy4_reg;
        end
    end

    bts_locate u_locate_x (
        .clk   (clk),
        .en    (pipe_en),
        .coord (s1_u_reg),
        .size  (tex_w_reg),
        .loc   (loc_x)
    );

    bts_locate u_locate_y (
        .clk   (clk),
        .en    (pipe_en),
        .coord (s1_v_reg),
        .size  (tex_h_reg),
        .loc   (loc_y)
    );

    // texel indices wrap modulo the store depth
    always_comb
    begin
        idx00  = bts_pkg::TEX_ADDR_W'((bts_pkg::ROW_W + 1)'(row0_reg)
                                     + (bts_pkg::ROW_W + 1)'(x0_reg));
        idx10  = bts_pkg::TEX_ADDR_W'((bts_pkg::ROW_W + 1)'(row0_reg)
                                     + (bts_pkg::ROW_W + 1)'(x1_reg));
        idx01  = bts_pkg::TEX_ADDR_W'((bts_pkg::ROW_W + 1)'(row1_reg)
                                     + (bts_pkg::ROW_W + 1)'(x0_reg));
        idx11  = bts_pkg::TEX_ADDR_W'((bts_pkg::ROW_W + 1)'(row1_reg)
                                     + (bts_pkg::ROW_W + 1)'(x1_reg));
        waddr  = bts_pkg::TEX_ADDR_W'(s4_addr_reg);
        ram_we = pipe_en && s4_valid_reg && (s4_cmd_reg == bts_pkg::CMD_WRITE)
              && (32'(s4_addr_reg) < 32'(bts_pkg::MAX_TEXELS));
    end

    bts_ram #(
        .DATA_W (bts_pkg::TEXEL_W),
        .DEPTH  (bts_pkg::MAX_TEXELS)
    ) u_ram_row0 (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (s4_texel_reg),
        .re      (pipe_en),
        .raddr_a (idx00),
        .raddr_b (idx10),
        .rdata_a (rd00),
        .rdata_b (rd10)
    );

    bts_ram #(
        .DATA_W (bts_pkg::TEXEL_W),
        .DEPTH  (bts_pkg::MAX_TEXELS)
    ) u_ram_row1 (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (s4_texel_reg),
        .re      (pipe_en),
        .raddr_a (idx01),
        .raddr_b (idx11),
        .rdata_a (rd01),
        .rdata_b (rd11)
    );

    bts_blend u_blend (
        .clk    (clk),
        .en     (pipe_en),
        .t00    (bts_pkg::texel_t'(rd00)),
        .t10    (bts_pkg::texel_t'(rd10)),
        .t01    (bts_pkg::texel_t'(rd01)),
        .t11    (bts_pkg::texel_t'(rd11)),
        .wx     (wx5_reg),
        .wy     (wy5_reg),
        .result (result)
    );

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (push)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hdl/bts_checker.sv
// bts_checker: port-level assertions for the bilinear texture sampler, bound to the top
// depends on bts_pkg and bilinear_texture_sampler

module bts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bts_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // input is only held off while a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // backpressure only follows a stalled output beat
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
